/* design/grid_dda_ray_cast_assert.svh */
// Assertion macros shared by the ray caster modules.
`ifndef GRID_DDA_RAY_CAST_ASSERT_SVH
`define GRID_DDA_RAY_CAST_ASSERT_SVH

// Checked while out of reset.
`define GDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define GDR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/gdr_pkg.sv */
package gdr_pkg;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 48;
  localparam int DIV_W       = 48;
  localparam int DVS_W       = 16;

  localparam int SINE_TABLE_DEPTH = 1024;

  localparam logic [31:0] POLY_A      = 32'd1686629694;
  localparam logic [31:0] POLY_B      = 32'd688904926;
  localparam logic [31:0] POLY_C      = 32'd76016958;
  localparam logic [16:0] DIST_LIMIT  = 17'd93061;
  localparam logic [31:0] QUARTER     = 32'h4000_0000;
  localparam logic [40:0] STEP_SAT    = 41'h100_0000_0000;
  localparam logic [23:0] MASK24      = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    CFG_MAP_W  = 2'd0,
    CFG_MAP_H  = 2'd1,
    CFG_TILE_W = 2'd2,
    CFG_TILE_H = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_CAST  = 1'b1
  } action_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

/* design/gdr_mul.sv */
module gdr_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);
  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;
endmodule

/* design/gdr_div.sv */
`include "grid_dda_ray_cast_assert.svh"
module gdr_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gdr_pkg::div_req_t req_i,
  output gdr_pkg::div_rsp_t rsp_o
);
  import gdr_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [DIV_W-1:0] quot_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   sh;
  logic             fit;

  assign sh  = {rem_q, quot_q[DIV_W-1]};
  assign fit = sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quot_q <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        quot_q <= req_i.dividend;
        rem_q  <= '0;
        dvs_q  <= req_i.divisor;
      end else if (busy_q) begin
        rem_q  <= fit ? DVS_W'(sh - {1'b0, dvs_q}) : sh[DVS_W-1:0];
        quot_q <= {quot_q[DIV_W-2:0], fit};
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == CW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

  `GDR_ASSERT(a_start_idle, req_i.start |-> !busy_q, "divide started while busy")
  `GDR_ASSERT(a_start_busy, req_i.start |=> busy_q, "divider did not start")
  `GDR_ASSERT(a_done_idle, rsp_o.done |-> !busy_q, "done raised while busy")
endmodule

/* design/gdr_map_mem.sv */
module gdr_map_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o,
  output logic          clr_busy_o
);
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_q;
  logic [AW-1:0] clr_q;
  logic          clr_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == AW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_q] <= 8'd0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clr_busy_o = clr_busy_q;
endmodule

/* design/grid_dda_ray_cast.sv */
// Grid ray caster. Write beats (tuser = 0) store one map cell and give no result;
// cells outside map_width x map_height are dropped. Cast beats (tuser = 1)
// convert the position to tile units, build the direction from a quarter-wave sine
// polynomial and walk the map with a DDA until a cell holding 1 is met or the distance
// reaches 1.42 times the larger map side; one result beat follows, with tuser = 1 and
// the hit point, or all zeros. One item is in work at a time. A cast runs the four
// divisions on the shared bit-serial divider (a zero direction component skips its step
// division), the polynomial and crossing set-up on the shared multiplier, the grid steps
// (one map memory read each, none for a cell outside the map) and the hit point, and
// then loads the result register. After reset the map memory is cleared one cell a
// cycle, all MAP_MAX_WIDTH x MAP_MAX_HEIGHT cells, while no beat is taken; configuration
// writes are taken at any time.
`include "grid_dda_ray_cast_assert.svh"
module grid_dda_ray_cast #(
  parameter int MAP_MAX_WIDTH    = 64,
  parameter int MAP_MAX_HEIGHT   = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [15:0]                        cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // cell_x, cell_y, cell_value, pos_x, pos_y, angle, zero pad
  input  logic [gdr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // action
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // hit_x, hit_y
  output logic [gdr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // hit
  output logic [0:0]                         m_axis_tuser
);
  import gdr_pkg::*;

  localparam int DEPTH = MAP_MAX_WIDTH * MAP_MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = $clog2(SINE_TABLE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE, S_PX, S_PY,
    S_SN0, S_SN1, S_SN2, S_SN3, S_SN4, S_SN5, S_SN6, S_SN7, S_SN8,
    S_SL, S_G0, S_G1,
    S_LP, S_LA, S_LC,
    S_W0, S_W1, S_W2, S_W3, S_W4,
    S_FIN
  } state_e;

  state_e state_q;

  logic [6:0]  map_w_q, map_h_q;
  logic [15:0] tile_w_q, tile_h_q;
  logic [6:0]  w_eff, h_eff, max_wh;
  logic [15:0] tw_eff, th_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q  <= '0;
      map_h_q  <= '0;
      tile_w_q <= 16'd256;
      tile_h_q <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MAP_W:  map_w_q  <= cfg_wdata_i[6:0];
        CFG_MAP_H:  map_h_q  <= cfg_wdata_i[6:0];
        CFG_TILE_W: tile_w_q <= cfg_wdata_i;
        CFG_TILE_H: tile_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign w_eff  = (32'(map_w_q) > MAP_MAX_WIDTH) ? 7'(MAP_MAX_WIDTH) : map_w_q;
  assign h_eff  = (32'(map_h_q) > MAP_MAX_HEIGHT) ? 7'(MAP_MAX_HEIGHT) : map_h_q;
  assign max_wh = (w_eff > h_eff) ? w_eff : h_eff;
  assign tw_eff = (tile_w_q == '0) ? 16'd1 : tile_w_q;
  assign th_eff = (tile_h_q == '0) ? 16'd1 : tile_h_q;

  // input beat fields
  logic [5:0]  in_x, in_y;
  logic [7:0]  in_val;
  logic [23:0] in_px, in_py;
  logic [15:0] in_ang;
  logic        in_acc;
  logic [31:0] idx_full;

  assign in_x     = s_axis_tdata[5:0];
  assign in_y     = s_axis_tdata[11:6];
  assign in_val   = s_axis_tdata[19:12];
  assign in_px    = s_axis_tdata[43:20];
  assign in_py    = s_axis_tdata[67:44];
  assign in_ang   = s_axis_tdata[83:68];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign idx_full = (32'(in_ang) * 32'(SINE_TABLE_DEPTH)) >> 16;

  // map memory
  logic          mem_we, mem_re, clr_busy;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_rdata;

  assign mem_we    = in_acc && (action_e'(s_axis_tuser[0]) == ACT_WRITE) &&
                     (7'(in_x) < w_eff) && (7'(in_y) < h_eff);
  assign mem_waddr = AW'(32'(in_y) * 32'(MAP_MAX_WIDTH) + 32'(in_x));

  gdr_map_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (mem_we),
    .waddr_i    (mem_waddr),
    .wdata_i    (in_val),
    .re_i       (mem_re),
    .raddr_i    (mem_raddr),
    .rdata_o    (mem_rdata),
    .clr_busy_o (clr_busy)
  );

  // datapath registers
  logic [23:0]        pos_x_q, pos_y_q, maxd_q;
  logic [39:0]        px_q, py_q;
  logic [31:0]        ph_q;
  logic               axis_q, div_run_q, hit_q;
  logic [1:0]         quad_q;
  logic [30:0]        x_q, x2_q, t_q;
  logic signed [15:0] dx_q, dy_q;
  logic [40:0]        sx_q, sy_q;
  logic [41:0]        gx_q, gy_q, dist_q;
  logic signed [25:0] cx_q, cy_q;
  logic [39:0]        q_q;
  logic [35:0]        hi_q;
  logic [23:0]        wx_q, wy_q;
  logic               m_valid_q, m_hit_q;
  logic [23:0]        m_x_q, m_y_q;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  gdr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  gdr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // per-axis selection
  logic signed [15:0] d_cur;
  logic [14:0]        m_cur;
  logic [39:0]        p_cur;
  logic [15:0]        tile_cur;
  logic [40:0]        s_cur;
  logic [16:0]        frac;
  logic [31:0]        phase;
  logic [31:0]        r_poly;
  logic [17:0]        v_rnd;
  logic [14:0]        v_clp;
  logic signed [15:0] d_val;
  logic signed [42:0] q_sum;
  logic [32:0]        off;
  logic [56:0]        w_sum;
  logic [23:0]        w_clp;
  logic               dx_pos, dx_neg, dy_pos, dy_neg, in_map;

  assign d_cur    = axis_q ? dy_q : dx_q;
  assign m_cur    = d_cur[15] ? 15'(-d_cur) : d_cur[14:0];
  assign p_cur    = axis_q ? py_q : px_q;
  assign tile_cur = axis_q ? th_eff : tw_eff;
  assign s_cur    = axis_q ? sy_q : sx_q;
  assign frac     = (!d_cur[15] && d_cur != '0) ? (17'h1_0000 - 17'(p_cur[15:0]))
                                               : 17'(p_cur[15:0]);
  assign phase    = axis_q ? ph_q : (ph_q + QUARTER);

  assign r_poly = mul_p[61:30];
  assign v_rnd  = 18'((33'(r_poly) + 33'h4000) >> 15);
  assign v_clp  = (v_rnd > 18'd32767) ? 15'h7FFF : v_rnd[14:0];
  assign d_val  = quad_q[1] ? -$signed({1'b0, v_clp}) : $signed({1'b0, v_clp});

  assign off   = mul_p[47:15];
  assign q_sum = d_cur[15] ? ($signed({3'b0, p_cur}) - $signed({10'b0, off}))
                           : ($signed({3'b0, p_cur}) + $signed({10'b0, off}));
  assign w_sum = 57'({hi_q, 20'b0}) + 57'(mul_p[35:0]);
  assign w_clp = (w_sum[56:40] != '0) ? MASK24 : w_sum[39:16];

  assign dx_pos = !dx_q[15] && dx_q != '0;
  assign dx_neg = dx_q[15];
  assign dy_pos = !dy_q[15] && dy_q != '0;
  assign dy_neg = dy_q[15];
  assign in_map = !cx_q[25] && !cy_q[25] && (cx_q < 26'(w_eff)) && (cy_q < 26'(h_eff));

  assign mem_re    = (state_q == S_LA) && in_map;
  assign mem_raddr = AW'(32'(cy_q[6:0]) * 32'(MAP_MAX_WIDTH) + 32'(cx_q[6:0]));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SN1: begin
        mul_a = 32'(x_q);
        mul_b = 32'(x_q);
      end
      S_SN3: begin
        mul_a = POLY_C;
        mul_b = 32'(x2_q);
      end
      S_SN5: begin
        mul_a = 32'(t_q);
        mul_b = 32'(x2_q);
      end
      S_SN7: begin
        mul_a = 32'(t_q);
        mul_b = 32'(x_q);
      end
      S_G0: begin
        mul_a = 32'(frac);
        mul_b = s_cur[31:0];
      end
      S_W0: begin
        mul_a = 32'(m_cur);
        mul_b = dist_q[31:0];
      end
      S_W2: begin
        mul_a = 32'(q_q[39:20]);
        mul_b = 32'(tile_cur);
      end
      S_W3: begin
        mul_a = 32'(q_q[19:0]);
        mul_b = 32'(tile_cur);
      end
      default: ;
    endcase
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_q)
      S_PX: begin
        div_req.start    = !div_run_q;
        div_req.dividend = DIV_W'({pos_x_q, 16'b0});
        div_req.divisor  = tw_eff;
      end
      S_PY: begin
        div_req.start    = !div_run_q;
        div_req.dividend = DIV_W'({pos_y_q, 16'b0});
        div_req.divisor  = th_eff;
      end
      S_SL: begin
        div_req.start    = !div_run_q && (m_cur != '0);
        div_req.dividend = DIV_W'(32'h8000_0000);
        div_req.divisor  = DVS_W'(m_cur);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      maxd_q    <= '0;
      px_q      <= '0;
      py_q      <= '0;
      ph_q      <= '0;
      axis_q    <= 1'b0;
      div_run_q <= 1'b0;
      hit_q     <= 1'b0;
      quad_q    <= '0;
      x_q       <= '0;
      x2_q      <= '0;
      t_q       <= '0;
      dx_q      <= '0;
      dy_q      <= '0;
      sx_q      <= '0;
      sy_q      <= '0;
      gx_q      <= '0;
      gy_q      <= '0;
      dist_q    <= '0;
      cx_q      <= '0;
      cy_q      <= '0;
      q_q       <= '0;
      hi_q      <= '0;
      wx_q      <= '0;
      wy_q      <= '0;
      m_valid_q <= 1'b0;
      m_hit_q   <= 1'b0;
      m_x_q     <= '0;
      m_y_q     <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && state_q != S_FIN) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && action_e'(s_axis_tuser[0]) == ACT_CAST) begin
            pos_x_q <= in_px;
            pos_y_q <= in_py;
            ph_q    <= 32'(idx_full[IW-1:0]) << (32 - IW);
            maxd_q  <= 24'(32'(max_wh) * 32'(DIST_LIMIT));
            axis_q  <= 1'b0;
            hit_q   <= 1'b0;
            state_q <= S_PX;
          end
        end
        S_PX, S_PY: begin
          if (!div_run_q) begin
            div_run_q <= 1'b1;
          end else if (div_rsp.done) begin
            div_run_q <= 1'b0;
            if (state_q == S_PX) begin
              px_q    <= div_rsp.quot[39:0];
              state_q <= S_PY;
            end else begin
              py_q    <= div_rsp.quot[39:0];
              state_q <= S_SN0;
            end
          end
        end
        S_SN0: begin
          quad_q  <= phase[31:30];
          x_q     <= phase[30] ? (31'h4000_0000 - {1'b0, phase[29:0]})
                               : {1'b0, phase[29:0]};
          state_q <= S_SN1;
        end
        S_SN1: state_q <= S_SN2;
        S_SN2: begin
          x2_q    <= mul_p[60:30];
          state_q <= S_SN3;
        end
        S_SN3: state_q <= S_SN4;
        S_SN4: begin
          t_q     <= 31'(POLY_B - mul_p[61:30]);
          state_q <= S_SN5;
        end
        S_SN5: state_q <= S_SN6;
        S_SN6: begin
          t_q     <= 31'(POLY_A - mul_p[61:30]);
          state_q <= S_SN7;
        end
        S_SN7: state_q <= S_SN8;
        S_SN8: begin
          if (!axis_q) begin
            dx_q    <= d_val;
            axis_q  <= 1'b1;
            state_q <= S_SN0;
          end else begin
            dy_q    <= d_val;
            axis_q  <= 1'b0;
            state_q <= S_SL;
          end
        end
        S_SL: begin
          if (m_cur == '0 || (div_run_q && div_rsp.done)) begin
            div_run_q <= 1'b0;
            if (!axis_q) begin
              sx_q <= (m_cur == '0) ? STEP_SAT : 41'(div_rsp.quot[31:0]);
            end else begin
              sy_q <= (m_cur == '0) ? STEP_SAT : 41'(div_rsp.quot[31:0]);
            end
            axis_q  <= !axis_q;
            state_q <= axis_q ? S_G0 : S_SL;
          end else if (!div_run_q) begin
            div_run_q <= 1'b1;
          end
        end
        S_G0: state_q <= S_G1;
        S_G1: begin
          if (!axis_q) begin
            gx_q    <= (d_cur == '0) ? 42'(STEP_SAT) : 42'(mul_p[48:16]);
            axis_q  <= 1'b1;
            state_q <= S_G0;
          end else begin
            gy_q    <= (d_cur == '0) ? 42'(STEP_SAT) : 42'(mul_p[48:16]);
            axis_q  <= 1'b0;
            cx_q    <= $signed({2'b0, px_q[39:16]});
            cy_q    <= $signed({2'b0, py_q[39:16]});
            dist_q  <= '0;
            state_q <= S_LP;
          end
        end
        S_LP: begin
          if (dist_q >= 42'(maxd_q)) begin
            state_q <= S_FIN;
          end else if (gx_q < gy_q) begin
            cx_q    <= cx_q + (dx_pos ? 26'sd1 : (dx_neg ? -26'sd1 : 26'sd0));
            dist_q  <= gx_q;
            gx_q    <= gx_q + 42'(sx_q);
            state_q <= S_LA;
          end else begin
            cy_q    <= cy_q + (dy_pos ? 26'sd1 : (dy_neg ? -26'sd1 : 26'sd0));
            dist_q  <= gy_q;
            gy_q    <= gy_q + 42'(sy_q);
            state_q <= S_LA;
          end
        end
        S_LA: state_q <= in_map ? S_LC : S_LP;
        S_LC: begin
          if (mem_rdata == 8'd1) begin
            hit_q   <= 1'b1;
            axis_q  <= 1'b0;
            state_q <= S_W0;
          end else begin
            state_q <= S_LP;
          end
        end
        S_W0: state_q <= S_W1;
        S_W1: begin
          priority if (q_sum[42] || q_sum == '0) begin
            if (!axis_q) wx_q <= '0;
            else wy_q <= '0;
            axis_q  <= !axis_q;
            state_q <= axis_q ? S_FIN : S_W0;
          end else if (q_sum[41:40] != '0) begin
            if (!axis_q) wx_q <= MASK24;
            else wy_q <= MASK24;
            axis_q  <= !axis_q;
            state_q <= axis_q ? S_FIN : S_W0;
          end else begin
            q_q     <= q_sum[39:0];
            state_q <= S_W2;
          end
        end
        S_W2: state_q <= S_W3;
        S_W3: begin
          hi_q    <= mul_p[35:0];
          state_q <= S_W4;
        end
        S_W4: begin
          if (!axis_q) wx_q <= w_clp;
          else wy_q <= w_clp;
          axis_q  <= !axis_q;
          state_q <= axis_q ? S_FIN : S_W0;
        end
        S_FIN: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_hit_q   <= hit_q;
            m_x_q     <= hit_q ? wx_q : '0;
            m_y_q     <= hit_q ? wy_q : '0;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready   = (state_q == S_IDLE) && !clr_busy;
  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = {m_y_q, m_x_q};
  assign m_axis_tuser[0] = m_hit_q;

  `GDR_ASSERT(a_rd_then_chk, mem_re |=> (state_q == S_LC), "map read not followed by check")
  `GDR_ASSERT(a_miss_zero, (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0),
              "miss beat carries a nonzero point")
  `GDR_ASSERT(a_dist_narrow, (state_q == S_W0) |-> (dist_q[41:32] == '0),
              "hit distance exceeds multiplier operand")
endmodule
